FILE: src/tbt_pkg.sv
// ---------------------------------------------------------------------------
// tbt_pkg: shared widths and constants
// Field widths of the vertex and result items, shared by the interfaces
// and the tangent/bitangent datapath.
// ---------------------------------------------------------------------------
package tbt_pkg;

    localparam int IN_W   = 24;     // Q8.16 vertex fields
    localparam int OUT_W  = 16;     // Q1.14 unit vector fields
    localparam int FRAC_O = 14;     // fraction bits of the outputs

endpackage

FILE: src/tbt_vtx_if.sv
// ---------------------------------------------------------------------------
// tbt_vtx_if: vertex channel
// valid/ready channel carrying one vertex (position and texcoords) per item.
// ---------------------------------------------------------------------------
interface tbt_vtx_if import tbt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  pos_x;
    logic signed [IN_W-1:0]  pos_y;
    logic signed [IN_W-1:0]  pos_z;
    logic signed [IN_W-1:0]  tex_u;
    logic signed [IN_W-1:0]  tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

FILE: src/tbt_res_if.sv
// ---------------------------------------------------------------------------
// tbt_res_if: result channel
// valid/ready channel carrying one tangent/bitangent pair per item.
// ---------------------------------------------------------------------------
interface tbt_res_if import tbt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] tan_x;
    logic signed [OUT_W-1:0] tan_y;
    logic signed [OUT_W-1:0] tan_z;
    logic signed [OUT_W-1:0] bitan_x;
    logic signed [OUT_W-1:0] bitan_y;
    logic signed [OUT_W-1:0] bitan_z;
    logic                    degenerate;

    modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    degenerate, input ready);
    modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    degenerate, output ready);
endinterface

FILE: src/triangle_tangent_bitangent_unit.sv
// ---------------------------------------------------------------------------
// triangle_tangent_bitangent_unit: per-triangle tangent/bitangent
// Gathers three vertices, then computes unit tangent and bitangent in Q1.14
// on a shared multiplier plus a shift-subtract sequencer.
// ---------------------------------------------------------------------------
// Vertices are taken one item at a time in triangle order. The first two
// vertices of a triangle are only stored and give no result. The third
// starts the sequencer and the block drops ready until its result has been
// taken. For a third vertex the sequencer forms the 14 products of the
// determinant and the two raw vectors (one 32x32 multiplier, multiply then
// accumulate), checks the determinant, then for each vector: a load,
// one-bit normalizing shifts, the sum of squares, the square-root iteration
// and the three restoring divisions. The sequence is shorter when the
// determinant or a vector is zero. The tangent is
// sign(det)*(d2v*e1 - d1v*e2), the bitangent
// sign(det)*(d1u*e2 - d2u*e1); degenerate is set on a zero determinant
// (both vectors zero) or on a zero vector (that vector zero).
// ---------------------------------------------------------------------------
module triangle_tangent_bitangent_unit import tbt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbt_vtx_if.sink     i_vtx,
    tbt_res_if.source   o_res
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL   = 13'b0000000000010,
        S_ACC   = 13'b0000000000100,
        S_CHK   = 13'b0000000001000,
        S_LOAD  = 13'b0000000010000,
        S_NORM  = 13'b0000000100000,
        S_SQ    = 13'b0000001000000,
        S_SQA   = 13'b0000010000000,
        S_SQRT  = 13'b0000100000000,
        S_DINIT = 13'b0001000000000,
        S_DIV   = 13'b0010000000000,
        S_DST   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    localparam int VW = 52;     // raw vector / determinant width
    localparam int MW = 51;     // magnitude width
    localparam logic [MW-1:0] NORM_LO = MW'(64'd1 << 29);
    localparam logic [MW-1:0] NORM_HI = MW'(64'd1 << 30);
    localparam logic [63:0]   SQ_TOP  = 64'd1 << 62;

    t_state r_state, n_state;
    logic [1:0] r_phase;

    // held vertices and the third vertex
    logic signed [IN_W-1:0] r_p0 [3];
    logic signed [IN_W-1:0] r_p1 [3];
    logic signed [IN_W-1:0] r_p2 [3];
    logic signed [IN_W-1:0] r_t0 [2];
    logic signed [IN_W-1:0] r_t1 [2];
    logic signed [IN_W-1:0] r_t2 [2];

    // product sequencer
    logic [3:0]             r_k;
    logic signed [63:0]     r_prod;
    logic signed [63:0]     r_acc;
    logic signed [VW-1:0]   r_det;
    logic signed [VW-1:0]   r_vec [6];     // tangent 0..2, bitangent 3..5

    // normalize / sqrt / divide
    logic                   r_vsel;
    logic [MW-1:0]          r_m [3];
    logic                   r_neg [3];
    logic [1:0]             r_j;
    logic [63:0]            r_sum;
    logic [63:0]            r_x;
    logic [63:0]            r_root;
    logic [63:0]            r_bit;
    logic [45:0]            r_num;
    logic [45:0]            r_den;
    logic [14:0]            r_q;
    logic [3:0]             r_cnt;

    // results
    logic signed [OUT_W-1:0] r_tan [3];
    logic signed [OUT_W-1:0] r_btn [3];
    logic                    r_degen;

    wire w_in_acc  = i_vtx.valid && i_vtx.ready;
    wire w_out_acc = o_res.valid && o_res.ready;
    wire [1:0] w_ph = (r_phase == 2'd3) ? 2'd0 : r_phase;

    // edges and uv deltas
    logic signed [IN_W:0] w_e1 [3];
    logic signed [IN_W:0] w_e2 [3];
    logic signed [IN_W:0] w_d1u, w_d1v, w_d2u, w_d2v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_e1[i] = (IN_W+1)'(r_p1[i]) - (IN_W+1)'(r_p0[i]);
            w_e2[i] = (IN_W+1)'(r_p2[i]) - (IN_W+1)'(r_p0[i]);
        end
        w_d1u = (IN_W+1)'(r_t1[0]) - (IN_W+1)'(r_t0[0]);
        w_d1v = (IN_W+1)'(r_t1[1]) - (IN_W+1)'(r_t0[1]);
        w_d2u = (IN_W+1)'(r_t2[0]) - (IN_W+1)'(r_t0[0]);
        w_d2v = (IN_W+1)'(r_t2[1]) - (IN_W+1)'(r_t0[1]);
    end

    // shared multiplier operand select
    logic signed [IN_W:0] w_fa, w_fb;
    logic signed [31:0]   w_ma, w_mb;
    wire [2:0] w_pair = r_k[3:1];

    always_comb begin
        w_fa = w_d1u;
        w_fb = w_d2v;
        unique case (w_pair)
            3'd0:    begin w_fa = r_k[0] ? w_d2u : w_d1u; w_fb = r_k[0] ? w_d1v : w_d2v; end
            3'd1:    begin w_fa = r_k[0] ? w_d1v : w_d2v; w_fb = r_k[0] ? w_e2[0] : w_e1[0]; end
            3'd2:    begin w_fa = r_k[0] ? w_d1v : w_d2v; w_fb = r_k[0] ? w_e2[1] : w_e1[1]; end
            3'd3:    begin w_fa = r_k[0] ? w_d1v : w_d2v; w_fb = r_k[0] ? w_e2[2] : w_e1[2]; end
            3'd4:    begin w_fa = r_k[0] ? w_d2u : w_d1u; w_fb = r_k[0] ? w_e1[0] : w_e2[0]; end
            3'd5:    begin w_fa = r_k[0] ? w_d2u : w_d1u; w_fb = r_k[0] ? w_e1[1] : w_e2[1]; end
            3'd6:    begin w_fa = r_k[0] ? w_d2u : w_d1u; w_fb = r_k[0] ? w_e1[2] : w_e2[2]; end
            default: begin w_fa = w_d1u; w_fb = w_d2v; end
        endcase
        if (r_state == S_SQ) begin
            w_ma = $signed({2'b00, r_m[r_j][29:0]});
            w_mb = $signed({2'b00, r_m[r_j][29:0]});
        end else begin
            w_ma = 32'(w_fa);
            w_mb = 32'(w_fb);
        end
    end

    // current vector, magnitudes and the largest one
    logic signed [VW-1:0] w_v [3];
    logic [MW-1:0]        w_mx;
    logic                 w_vzero;
    wire  signed [63:0]   w_diff = r_acc - r_prod;

    always_comb begin
        for (int i = 0; i < 3; i++)
            w_v[i] = r_vsel ? r_vec[3+i] : r_vec[i];
        w_vzero = (w_v[0] == '0) && (w_v[1] == '0) && (w_v[2] == '0);
        w_mx = r_m[0];
        if (r_m[1] > w_mx) w_mx = r_m[1];
        if (r_m[2] > w_mx) w_mx = r_m[2];
    end

    wire [63:0] w_trial  = r_root + r_bit;
    wire        w_sq_ge  = r_x >= w_trial;
    wire        w_div_ge = r_num >= r_den;
    wire [15:0] w_qext   = {1'b0, r_q};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc && w_ph == 2'd2) n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = (r_k == 4'd13) ? S_CHK : S_MUL;
            S_CHK:   n_state = (r_det == '0) ? S_OUT : S_LOAD;
            S_LOAD:  if (!w_vzero) n_state = S_NORM;
                     else if (r_vsel) n_state = S_OUT;
            S_NORM:  if (w_mx >= NORM_LO && w_mx < NORM_HI) n_state = S_SQ;
            S_SQ:    n_state = S_SQA;
            S_SQA:   n_state = (r_j == 2'd2) ? S_SQRT : S_SQ;
            S_SQRT:  if (r_bit == 64'd1) n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   if (r_cnt == 4'd0) n_state = S_DST;
            S_DST:   if (r_j == 2'd2) n_state = r_vsel ? S_OUT : S_LOAD;
                     else n_state = S_DINIT;
            S_OUT:   if (w_out_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) r_phase <= (w_ph == 2'd2) ? 2'd0 : w_ph + 2'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    priority case (w_ph)
                        2'd0: begin
                            r_p0[0] <= i_vtx.pos_x; r_p0[1] <= i_vtx.pos_y;
                            r_p0[2] <= i_vtx.pos_z;
                            r_t0[0] <= i_vtx.tex_u; r_t0[1] <= i_vtx.tex_v;
                        end
                        2'd1: begin
                            r_p1[0] <= i_vtx.pos_x; r_p1[1] <= i_vtx.pos_y;
                            r_p1[2] <= i_vtx.pos_z;
                            r_t1[0] <= i_vtx.tex_u; r_t1[1] <= i_vtx.tex_v;
                        end
                        default: begin
                            r_p2[0] <= i_vtx.pos_x; r_p2[1] <= i_vtx.pos_y;
                            r_p2[2] <= i_vtx.pos_z;
                            r_t2[0] <= i_vtx.tex_u; r_t2[1] <= i_vtx.tex_v;
                        end
                    endcase
                end
                r_k     <= 4'd0;
                r_vsel  <= 1'b0;
                r_degen <= 1'b0;
            end
            S_MUL: r_prod <= w_ma * w_mb;
            S_ACC: begin
                if (!r_k[0]) begin
                    r_acc <= r_prod;
                end else if (w_pair == 3'd0) begin
                    r_det <= VW'(w_diff);
                end else begin
                    r_vec[3'(w_pair - 3'd1)] <= VW'(w_diff);
                end
                r_k <= r_k + 4'd1;
            end
            S_CHK: begin
                // zero determinant: both vectors zero
                if (r_det == '0) begin
                    r_degen <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        r_tan[i] <= '0;
                        r_btn[i] <= '0;
                    end
                end
            end
            S_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= w_v[i][VW-1] ? MW'(-w_v[i]) : MW'(w_v[i]);
                    r_neg[i] <= w_v[i][VW-1] ^ r_det[VW-1];
                end
                r_j <= 2'd0;
                if (w_vzero) begin
                    r_degen <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        if (r_vsel) r_btn[i] <= '0;
                        else        r_tan[i] <= '0;
                    end
                    r_vsel <= 1'b1;
                end
            end
            S_NORM: begin
                r_sum <= '0;
                for (int i = 0; i < 3; i++) begin
                    if (w_mx < NORM_LO)       r_m[i] <= r_m[i] << 1;
                    else if (w_mx >= NORM_HI) r_m[i] <= r_m[i] >> 1;
                end
            end
            S_SQ: r_prod <= w_ma * w_mb;
            S_SQA: begin
                r_sum  <= r_sum + 64'(r_prod);
                r_j    <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                r_x    <= r_sum + 64'(r_prod);
                r_root <= '0;
                r_bit  <= SQ_TOP;
            end
            S_SQRT: begin
                if (w_sq_ge) begin
                    r_x    <= r_x - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DINIT: begin
                // round half up: (m*2^14 + len/2) / len
                r_num <= ({16'd0, r_m[r_j][29:0]} << FRAC_O) + {15'd0, r_root[31:1]};
                r_den <= {15'd0, r_root[30:0]} << FRAC_O;
                r_q   <= '0;
                r_cnt <= 4'd14;
            end
            S_DIV: begin
                if (w_div_ge) r_num <= r_num - r_den;
                r_den <= r_den >> 1;
                r_q   <= {r_q[13:0], w_div_ge};
                r_cnt <= r_cnt - 4'd1;
            end
            S_DST: begin
                if (r_vsel) r_btn[r_j] <= r_neg[r_j] ? -$signed(w_qext) : $signed(w_qext);
                else        r_tan[r_j] <= r_neg[r_j] ? -$signed(w_qext) : $signed(w_qext);
                r_j <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                if (r_j == 2'd2) r_vsel <= 1'b1;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    assign i_vtx.ready      = (r_state == S_IDLE);
    assign o_res.valid      = (r_state == S_OUT);
    assign o_res.tan_x      = r_tan[0];
    assign o_res.tan_y      = r_tan[1];
    assign o_res.tan_z      = r_tan[2];
    assign o_res.bitan_x    = r_btn[0];
    assign o_res.bitan_y    = r_btn[1];
    assign o_res.bitan_z    = r_btn[2];
    assign o_res.degenerate = r_degen;

`ifndef SYNTH
    // a result never overlaps a vertex accept
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_vtx.ready) else $error("result and ready overlap");

    // first and second vertices give no result
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_ph != 2'd2) |=> !o_res.valid) else $error("early result");

    // taking the result frees the block
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |=> i_vtx.ready) else $error("not ready after result");

    // zero determinant gives the flag and zero x components of both vectors
    a_det_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_det == '0) |-> (o_res.degenerate && o_res.tan_x == '0
        && o_res.bitan_x == '0)) else $error("zero determinant not flagged");
`endif

endmodule
